// ----- rtl/core/binary_majority_filter_5x5_defines.svh -----
`ifndef BINARY_MAJORITY_FILTER_5X5_DEFINES_SVH
`define BINARY_MAJORITY_FILTER_5X5_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define BMF5_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the following cycle.
`define BMF5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bmf5_pkg.sv -----
package bmf5_pkg;

  // Map limits and register widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 5;
  localparam int DIM_W      = 11;

  // Counter widths: output rows stay inside the map, input rows run two rows past it
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 3);

  // Window geometry
  localparam int WIN      = 5;
  localparam int CENTER   = 2;
  localparam int LB_ROWS  = WIN - 1;
  localparam int CCNT_W   = 3;
  localparam int CNT_W    = 5;
  localparam logic [CNT_W-1:0] KEEP_COUNT = 5'd12;

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [OROW_W-1:0]  orow_t;
  typedef logic [IROW_W-1:0]  irow_t;
  typedef logic [LB_ROWS-1:0] lb_word_t;
  typedef logic [WIN-1:0]     win_col_t;
  typedef logic [CCNT_W-1:0]  ccnt_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Position of the cell whose result an item yields
  typedef struct packed {
    orow_t orow;
    col_t  ocol;
  } pos_t;

  // One accepted request on its way to the window stage
  typedef struct packed {
    logic wall;
    col_t col;
    logic produce;
    logic last;
    pos_t pos;
  } stage_t;

  // Clamp a written dimension into the supported range
  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    if (v < dim_t'(MIN_DIM)) begin
      return dim_t'(MIN_DIM);
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/bmf5_channels.sv -----
// Input channel: one map cell per request
interface bmf5_in_if;
  logic valid;
  logic ready;
  logic cell_in;
  logic flush;

  modport source (output valid, cell_in, flush, input ready);
  modport sink   (input valid, cell_in, flush, output ready);
endinterface

// Output channel: one smoothed cell per request
interface bmf5_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic frame_last;

  modport source (output valid, cell_out, frame_last, input ready);
  modport sink   (input valid, cell_out, frame_last, output ready);
endinterface

// ----- rtl/core/bmf5_line_buffer.sv -----
module bmf5_line_buffer (
  input  logic              clk,
  input  logic              rd_en,
  input  bmf5_pkg::col_t    rd_addr,
  output bmf5_pkg::lb_word_t rd_data,
  input  logic              wr_en,
  input  bmf5_pkg::col_t    wr_addr,
  input  bmf5_pkg::lb_word_t wr_data
);

  // Four previous rows per column, newest row in bit 0
  bmf5_pkg::lb_word_t mem [bmf5_pkg::MAX_WIDTH];

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/bmf5_window.sv -----
module bmf5_window (
  input  logic               clk,
  input  logic               shift,
  input  logic               new_wall,
  input  bmf5_pkg::pos_t     pos,
  input  bmf5_pkg::lb_word_t lb_rd,
  input  bmf5_pkg::dim_t     map_width,
  input  bmf5_pkg::dim_t     map_height,
  output logic               cell_out,
  output bmf5_pkg::lb_word_t lb_wr
);

  // Older window columns; column k of the full window is k requests old
  bmf5_pkg::win_col_t win_q [bmf5_pkg::WIN-1];
  bmf5_pkg::win_col_t cur   [bmf5_pkg::WIN];
  logic [bmf5_pkg::WIN-1:0] col_ok;
  logic [bmf5_pkg::WIN-1:0] row_ok;
  bmf5_pkg::ccnt_t col_cnt [bmf5_pkg::WIN];
  bmf5_pkg::cnt_t  walls;
  logic            center;

  // Assemble the window: new column from the input cell over the line buffer rows
  always_comb begin
    cur[0] = {lb_rd, new_wall};
    for (int k = 1; k < bmf5_pkg::WIN; k++) begin
      cur[k] = win_q[k-1];
    end
  end

  // Advance the window by one column per request
  always_ff @(posedge clk) begin
    if (shift) begin
      win_q[0] <= cur[0];
      for (int k = 1; k < bmf5_pkg::WIN - 1; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // Push the column down the line buffer
  assign lb_wr = {lb_rd[bmf5_pkg::LB_ROWS-2:0], new_wall};

  // Mark window columns inside the map (column 0 is two right of the center)
  assign col_ok[0] = (bmf5_pkg::dim_t'(pos.ocol) + bmf5_pkg::dim_t'(2)) < map_width;
  assign col_ok[1] = (bmf5_pkg::dim_t'(pos.ocol) + bmf5_pkg::dim_t'(1)) < map_width;
  assign col_ok[2] = 1'b1;
  assign col_ok[3] = (pos.ocol != '0);
  assign col_ok[4] = (pos.ocol[bmf5_pkg::COL_W-1:1] != '0);

  // Mark window rows inside the map (bit 0 is two rows below the center)
  assign row_ok[0] = (bmf5_pkg::dim_t'(pos.orow) + bmf5_pkg::dim_t'(2)) < map_height;
  assign row_ok[1] = (bmf5_pkg::dim_t'(pos.orow) + bmf5_pkg::dim_t'(1)) < map_height;
  assign row_ok[2] = 1'b1;
  assign row_ok[3] = (pos.orow != '0);
  assign row_ok[4] = (pos.orow[bmf5_pkg::OROW_W-1:1] != '0);

  // Count walls per column, outside positions as walls, center left out
  always_comb begin
    for (int k = 0; k < bmf5_pkg::WIN; k++) begin
      col_cnt[k] = '0;
      for (int j = 0; j < bmf5_pkg::WIN; j++) begin
        if (!(k == bmf5_pkg::CENTER && j == bmf5_pkg::CENTER)) begin
          col_cnt[k] = col_cnt[k]
                     + bmf5_pkg::ccnt_t'({~(row_ok[j] & col_ok[k]) | cur[k][j]});
        end
      end
    end
  end

  // Sum the column counts
  always_comb begin
    walls = '0;
    for (int k = 0; k < bmf5_pkg::WIN; k++) begin
      walls = walls + bmf5_pkg::cnt_t'(col_cnt[k]);
    end
  end

  // Majority decision, tie keeps the center
  assign center = cur[bmf5_pkg::CENTER][bmf5_pkg::CENTER];

  always_comb begin
    if (walls > bmf5_pkg::KEEP_COUNT) begin
      cell_out = 1'b1;
    end else if (walls < bmf5_pkg::KEEP_COUNT) begin
      cell_out = 1'b0;
    end else begin
      cell_out = center;
    end
  end

endmodule

// ----- rtl/core/binary_majority_filter_5x5.sv -----
// Channel     Role     Payload                  Handshake
// map_cells   sink     cell_in, flush           valid / ready
// smoothed    source   cell_out, frame_last     valid / ready
// cfg         write    cfg_index, cfg_wdata     cfg_we, always taken
//
// One request per clock sustained while results are not stalled; a request is held
// in the input stage (line buffer read) and then enters the window stage, which
// loads the result register. Results trail requests by 2*map_width+2 items; the
// first ones of a frame give no result. Reset clears control state only: line
// buffer and window contents are masked by frame position. A stalled result
// holds the window stage, and the input stage then takes a request only while
// it is empty.
`include "binary_majority_filter_5x5_defines.svh"

module binary_majority_filter_5x5 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bmf5_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [bmf5_pkg::DIM_W-1:0]          cfg_wdata,
  bmf5_in_if.sink                             map_cells,
  bmf5_out_if.source                          smoothed
);

  bmf5_pkg::dim_t  map_width;
  bmf5_pkg::dim_t  map_height;
  bmf5_pkg::col_t  in_column;
  bmf5_pkg::irow_t in_row;
  bmf5_pkg::orow_t out_row;
  bmf5_pkg::col_t  out_col;

  bmf5_pkg::stage_t   s1;
  logic               s1_valid;
  logic               s1_adv;
  logic               accept;
  logic               acc_produce;
  logic               acc_last;
  logic               in_col_end;
  logic               out_col_end;
  bmf5_pkg::lb_word_t lb_rd;
  bmf5_pkg::lb_word_t lb_wr;
  logic               win_cell;

  logic out_valid;
  logic out_cell;
  logic out_last;

  // Handshake: the input stage empties whenever the window stage moves
  assign s1_adv          = s1_valid && (!out_valid || smoothed.ready);
  assign map_cells.ready = !s1_valid || s1_adv;
  assign accept          = map_cells.valid && map_cells.ready;

  // Frame position of the incoming request
  assign in_col_end  = (bmf5_pkg::dim_t'(in_column) == map_width - bmf5_pkg::dim_t'(1));
  assign out_col_end = (bmf5_pkg::dim_t'(out_col) == map_width - bmf5_pkg::dim_t'(1));
  assign acc_produce = (in_row > bmf5_pkg::irow_t'(2))
                    || (in_row == bmf5_pkg::irow_t'(2) && in_column >= bmf5_pkg::col_t'(2));
  assign acc_last    = acc_produce && out_col_end
                    && (bmf5_pkg::dim_t'(out_row) == map_height - bmf5_pkg::dim_t'(1));

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= bmf5_pkg::dim_t'(64);
      map_height <= bmf5_pkg::dim_t'(64);
      in_column  <= '0;
      in_row     <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else if (cfg_we) begin
      unique case (bmf5_pkg::reg_idx_t'(cfg_index))
        bmf5_pkg::REG_MAP_WIDTH: begin
          map_width <= bmf5_pkg::clamp_dim(cfg_wdata, bmf5_pkg::dim_t'(bmf5_pkg::MAX_WIDTH));
        end
        bmf5_pkg::REG_MAP_HEIGHT: begin
          map_height <= bmf5_pkg::clamp_dim(cfg_wdata,
                                            bmf5_pkg::dim_t'(bmf5_pkg::MAX_HEIGHT));
        end
      endcase
      in_column <= '0;
      in_row    <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (accept) begin
      if (acc_last) begin
        in_column <= '0;
        in_row    <= '0;
        out_row   <= '0;
        out_col   <= '0;
      end else begin
        if (in_col_end) begin
          in_column <= '0;
          in_row    <= in_row + bmf5_pkg::irow_t'(1);
        end else begin
          in_column <= in_column + bmf5_pkg::col_t'(1);
        end
        if (acc_produce) begin
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + bmf5_pkg::orow_t'(1);
          end else begin
            out_col <= out_col + bmf5_pkg::col_t'(1);
          end
        end
      end
    end
  end

  // Input stage: hold the request while its line buffer word is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.wall     <= map_cells.cell_in & ~map_cells.flush;
      s1.col      <= in_column;
      s1.produce  <= acc_produce;
      s1.last     <= acc_last;
      s1.pos.orow <= out_row;
      s1.pos.ocol <= out_col;
    end
  end

  bmf5_line_buffer u_line_buffer (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_column),
    .rd_data (lb_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (lb_wr)
  );

  bmf5_window u_window (
    .clk        (clk),
    .shift      (s1_adv),
    .new_wall   (s1.wall),
    .pos        (s1.pos),
    .lb_rd      (lb_rd),
    .map_width  (map_width),
    .map_height (map_height),
    .cell_out   (win_cell),
    .lb_wr      (lb_wr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1.produce;
    end else if (smoothed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.produce) begin
      out_cell <= win_cell;
      out_last <= s1.last;
    end
  end

  assign smoothed.valid      = out_valid;
  assign smoothed.cell_out   = out_cell;
  assign smoothed.frame_last = out_last;

  // Line buffer read and write never meet on one column inside a frame
  `BMF5_ASSERT_SAME(a_lb_port_split, accept && s1_adv && (in_column != '0), in_column != s1.col, "line buffer read and write hit the same column")
  // The last request of a frame restarts every frame counter
  `BMF5_ASSERT_NEXT(a_frame_restart, accept && acc_last, (in_column == '0) && (in_row == '0) && (out_row == '0) && (out_col == '0), "frame counters not restarted after frame end")
  // The result position stays inside the map
  `BMF5_ASSERT_SAME(a_out_pos_range, 1'b1, (bmf5_pkg::dim_t'(out_row) < map_height) && (bmf5_pkg::dim_t'(out_col) < map_width), "result position outside the map")

endmodule

// ----- tb/tb_binary_majority_filter_5x5.sv -----
`timescale 1ns / 100ps

module tb_binary_majority_filter_5x5;

  localparam int RUN_LIMIT     = 3_000_000;
  localparam int RANDOM_ITEMS  = 700;
  localparam int CALM_FROM     = 560;
  localparam int SETTLE_CYCLES = 8;
  localparam int RING          = 8;
  localparam int NO_CAP        = 32'h7fff_ffff;

  typedef struct {
    logic wall;
    logic last;
  } smoothed_t;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_NOISY,
    FRAME_CUT
  } frame_kind_t;

  // Majority predictor: keeps its own map rows, sizes and frame position
  class majority_board;
    bit [bmf5_pkg::MAX_WIDTH-1:0] ring_rows [RING];
    int map_w;
    int map_h;
    int frame_pos;
    smoothed_t pending_cells [$];
    int errors;
    int requests;
    int results;
    int frames;

    function new();
      map_w     = 64;
      map_h     = 64;
      frame_pos = 0;
      errors    = 0;
      requests  = 0;
      results   = 0;
      frames    = 0;
      foreach (ring_rows[i]) ring_rows[i] = '0;
    endfunction

    // Clamp a written size and restart the frame
    function void set_reg(bmf5_pkg::reg_idx_t idx, bmf5_pkg::dim_t val);
      int v;
      v = int'(val);
      if (v < bmf5_pkg::MIN_DIM) v = bmf5_pkg::MIN_DIM;
      if (idx == bmf5_pkg::REG_MAP_WIDTH)
        map_w = (v > bmf5_pkg::MAX_WIDTH) ? bmf5_pkg::MAX_WIDTH : v;
      else map_h = (v > bmf5_pkg::MAX_HEIGHT) ? bmf5_pkg::MAX_HEIGHT : v;
      frame_pos = 0;
    endfunction

    // Store an accepted request and queue the smoothed cell it yields
    function void take_cell(bit map_bit, bit flush);
      int cells, lag, q, r, c, rr, cc, dr, dc, walls;
      smoothed_t s;
      cells = map_w * map_h;
      lag   = 2 * map_w + 2;
      requests++;
      if (frame_pos < cells)
        ring_rows[(frame_pos / map_w) % RING][frame_pos % map_w] = flush ? 1'b0 : map_bit;
      if (frame_pos < lag) begin
        frame_pos++;
        return;
      end
      q = frame_pos - lag;
      r = q / map_w;
      c = q % map_w;
      // count walls around the center, off-map positions count as walls
      walls = 0;
      for (dr = -2; dr <= 2; dr++) begin
        for (dc = -2; dc <= 2; dc++) begin
          if (dr == 0 && dc == 0) continue;
          rr = r + dr;
          cc = c + dc;
          if (rr < 0 || rr >= map_h || cc < 0 || cc >= map_w) walls++;
          else walls += ring_rows[rr % RING][cc];
        end
      end
      if (walls > int'(bmf5_pkg::KEEP_COUNT)) s.wall = 1'b1;
      else if (walls < int'(bmf5_pkg::KEEP_COUNT)) s.wall = 1'b0;
      else s.wall = ring_rows[r % RING][c];
      s.last = (q + 1 >= cells);
      frame_pos = s.last ? 0 : frame_pos + 1;
      pending_cells = {pending_cells, s};
    endfunction

    // Compare one accepted result with the oldest pending cell
    function void check_smoothed(logic got_wall, logic last);
      smoothed_t want;
      results++;
      if (last === 1'b1) frames++;
      if (pending_cells.size() == 0) begin
        if (errors < 10)
          $display("[%0t] ERROR: cell %b last %b arrived with nothing pending",
                   $time, got_wall, last);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      if (got_wall !== want.wall || last !== want.last) begin
        if (errors < 10)
          $display("[%0t] ERROR: result %0d expected cell %b last %b, got cell %b last %b",
                   $time, results, want.wall, want.last, got_wall, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bmf5_pkg::REG_IDX_W-1:0] cfg_index;
  bmf5_pkg::dim_t cfg_wdata;

  bmf5_in_if  map_cells ();
  bmf5_out_if smoothed ();

  majority_board board;
  int gap_pct;
  int stall_pct;
  int sizes_used;

  binary_majority_filter_5x5 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .map_cells (map_cells),
    .smoothed  (smoothed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a run that stops making progress
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Drop ready in random bursts while stalls are enabled
  initial begin : ready_drive
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        smoothed.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      smoothed.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && smoothed.valid && smoothed.ready)
      board.check_smoothed(smoothed.cell_out, smoothed.frame_last);
  end

  function automatic int idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic pick_idling();
    gap_pct   = idle_pct();
    stall_pct = idle_pct();
  endtask

  // Present one request, hold it until taken
  task automatic send_cell(bit c, bit f);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      map_cells.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    map_cells.valid   <= 1'b1;
    map_cells.cell_in <= c;
    map_cells.flush   <= f;
    @(posedge clk);
    while (!map_cells.ready) @(posedge clk);
    board.take_cell(c, f);
  endtask

  // Wait for every pending result, then let the pipeline drain
  task automatic settle();
    map_cells.valid <= 1'b0;
    while (board.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one or both sizes on consecutive edges
  task automatic write_dims(bit do_w, bmf5_pkg::dim_t w, bit do_h, bmf5_pkg::dim_t h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= bmf5_pkg::REG_MAP_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
      board.set_reg(bmf5_pkg::REG_MAP_WIDTH, w);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= bmf5_pkg::REG_MAP_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
      board.set_reg(bmf5_pkg::REG_MAP_HEIGHT, h);
    end
    cfg_we <= 1'b0;
    sizes_used++;
  endtask

  // Send one frame of cells and padding at the current size
  task automatic send_frame(frame_kind_t kind, int density, int cap);
    int cells, lag, total, n;
    bit c, f;
    cells = board.map_w * board.map_h;
    lag   = 2 * board.map_w + 2;
    total = cells + lag;
    if (kind == FRAME_CUT) total = $urandom_range(1, total - 1);
    if (total > cap) total = cap;
    for (n = 0; n < total; n++) begin
      if (n < cells) begin
        c = ($urandom_range(0, 99) < density);
        f = (kind == FRAME_NOISY) && ($urandom_range(0, 99) < 8);
      end else begin
        c = $urandom_range(0, 1);
        f = (kind != FRAME_NOISY) || ($urandom_range(0, 1) == 1);
      end
      send_cell(c, f);
    end
  endtask

  // Smallest map, checkerboard so the center sits exactly at the tie count
  task automatic run_directed();
    int n;
    write_dims(1'b1, 11'd0, 1'b1, 11'd3);
    // corner cell carries a wall but is flushed, so it must store empty
    for (n = 0; n < 25; n++) send_cell(n[0] | (n == 24), n == 24);
    // padding with live cell data and flush low on some requests
    for (n = 0; n < 12; n++) send_cell(n[0], n[1]);
  endtask

  initial begin : main
    int k, frames_n, roll, sel, random_base;
    bmf5_pkg::dim_t w, h;
    bit first;
    frame_kind_t kind;

    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bmf5_pkg::REG_MAP_WIDTH;
    cfg_wdata = '0;
    map_cells.valid = 1'b0;
    map_cells.cell_in = 1'b0;
    map_cells.flush = 1'b0;
    smoothed.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    sizes_used = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: start of a frame before any write, dropped after some results
    send_frame(FRAME_CLEAN, 50, 300);
    settle();

    run_directed();
    settle();

    // Wide map, height clamped up from below
    pick_idling();
    write_dims(1'b1, 11'd40, 1'b1, 11'd4);
    send_frame(FRAME_CLEAN, 45, NO_CAP);
    settle();

    // Narrowest map, height clamped down from the top, frame dropped early
    pick_idling();
    write_dims(1'b1, 11'd0, 1'b1, 11'd2047);
    send_frame(FRAME_CLEAN, 55, 200);
    settle();

    // Largest sizes, frame dropped while the window is still filling
    pick_idling();
    write_dims(1'b1, 11'd2047, 1'b1, 11'd1024);
    send_frame(FRAME_CLEAN, 50, 80);
    settle();

    // Random sizes and frames, idling off for the tail
    random_base = board.requests;
    first = 1'b1;
    while (board.requests - random_base < RANDOM_ITEMS) begin
      if (board.requests - random_base >= CALM_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick_idling();
      end
      w = bmf5_pkg::dim_t'($urandom_range(5, 12));
      h = bmf5_pkg::dim_t'($urandom_range(5, 9));
      case ($urandom_range(0, 9))
        0: w = bmf5_pkg::dim_t'($urandom_range(0, 4));
        1: h = bmf5_pkg::dim_t'($urandom_range(0, 4));
        2: begin
          w = bmf5_pkg::dim_t'($urandom_range(13, 40));
          h = bmf5_pkg::dim_t'($urandom_range(5, 6));
        end
        default: ;
      endcase
      sel = first ? 0 : $urandom_range(0, 5);
      write_dims(sel != 1, w, sel != 2, h);
      first = 1'b0;
      frames_n = $urandom_range(1, 3);
      for (k = 0; k < frames_n; k++) begin
        roll = $urandom_range(0, 99);
        kind = (roll < 80) ? FRAME_CLEAN : (roll < 90) ? FRAME_NOISY : FRAME_CUT;
        send_frame(kind, $urandom_range(10, 90), NO_CAP);
        if (kind == FRAME_CUT) break;
      end
      settle();
    end

    $display("Sent %0d requests over %0d size settings; checked %0d results, %0d frame ends",
             board.requests, sizes_used, board.results, board.frames);
    $display("Mismatches: %0d", board.errors);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
